// ===== hw/rtl/byte_stuff_frame_encoder_macros.svh =====
// assertion helpers for the byte stuffing frame encoder
`ifndef BYTE_STUFF_FRAME_ENCODER_MACROS_SVH
`define BYTE_STUFF_FRAME_ENCODER_MACROS_SVH

// checked only while out of reset
`define BSFE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bsfe assertion failed");

// checked at every edge, reset included
`define BSFE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("bsfe assertion failed");

`endif

// ===== hw/rtl/bsfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bsfe_pkg;

  // line codes
  localparam logic [7:0] FlagStart = 8'h7E;
  localparam logic [7:0] FlagEnd   = 8'h8E;
  localparam logic [7:0] EscByte   = 8'h7D;
  localparam logic [7:0] EscFor7D  = 8'h5D;
  localparam logic [7:0] EscFor7E  = 8'h5E;
  localparam logic [7:0] EscFor8E  = 8'h6E;

  localparam logic [15:0] MaxOutReset = 16'd1024;
  localparam int unsigned FifoDepthDefault = 4;

  // one classified item: up to two line bytes
  typedef struct packed {
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic       two;
    logic       last;
  } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/byte_stuff_frame_encoder.sv =====
// an accepted item is registered in the queue; the back end loads its first line byte into the output register
// throughput: one item per cycle unless the output stalls; an escaped byte needs the byte slot for both line bytes
// items of a dropped frame leave the queue at one per cycle and give no output
// reset: async active low; frame state cleared, limit back to 1024, queue and output emptied
`timescale 1ns / 1ps
`default_nettype none

module byte_stuff_frame_encoder #(
  // entries in the queue between classifier and emitter
  parameter int unsigned FifoDepth = bsfe_pkg::FifoDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: output limit per frame
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  // raw message items
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        in_last_i,
  // encoded line items
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o,
  output logic             out_abort_o
);

  // front to queue
  logic             q_push;
  logic             q_full;
  bsfe_pkg::entry_t q_entry;
  // queue to back
  logic             head_valid;
  bsfe_pkg::entry_t head;
  logic             head_pop;

  // front: frame start tracking and escape classification
  bsfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  // short queue so each side stalls on its own
  bsfe_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_entry),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (head_pop)
  );

  // back: output count, limit check, abort and drop, output register
  bsfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (head_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .out_abort_o  (out_abort_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bsfe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsfe_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              in_last_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output bsfe_pkg::entry_t       q_entry_o
);

  // next item opens a frame when the previous one closed it
  logic first_q, first_d;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    first_d = first_q;
    if (q_push_o) begin
      first_d = in_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else begin
      first_q <= first_d;
    end
  end

  always_comb begin
    q_entry_o.byte1 = in_byte_i;
    q_entry_o.byte2 = 8'h00;
    q_entry_o.two   = 1'b0;
    q_entry_o.last  = in_last_i;
    if (in_last_i) begin
      q_entry_o.byte1 = bsfe_pkg::FlagEnd;
    end else if (first_q) begin
      q_entry_o.byte1 = bsfe_pkg::FlagStart;
    end else begin
      case (in_byte_i)
        bsfe_pkg::EscByte: begin
          q_entry_o.byte1 = bsfe_pkg::EscByte;
          q_entry_o.byte2 = bsfe_pkg::EscFor7D;
          q_entry_o.two   = 1'b1;
        end
        bsfe_pkg::FlagStart: begin
          q_entry_o.byte1 = bsfe_pkg::EscByte;
          q_entry_o.byte2 = bsfe_pkg::EscFor7E;
          q_entry_o.two   = 1'b1;
        end
        bsfe_pkg::FlagEnd: begin
          q_entry_o.byte1 = bsfe_pkg::EscByte;
          q_entry_o.byte2 = bsfe_pkg::EscFor8E;
          q_entry_o.two   = 1'b1;
        end
        default: begin
          q_entry_o.byte1 = in_byte_i;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bsfe_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsfe_fifo #(
  parameter int unsigned Depth = bsfe_pkg::FifoDepthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire bsfe_pkg::entry_t  push_entry_i,
  output logic                   full_o,
  output logic                   head_valid_o,
  output bsfe_pkg::entry_t       head_o,
  input  wire logic              pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  bsfe_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_pop;

  assign full_o       = (cnt_q == FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bsfe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "byte_stuff_frame_encoder_macros.svh"

module bsfe_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_wdata_i,
  input  wire logic              head_valid_i,
  input  wire bsfe_pkg::entry_t  head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [7:0]             out_byte_o,
  output logic                   out_last_o,
  output logic                   out_abort_o
);

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q, out_last_d;
  logic        out_abort_q, out_abort_d;
  logic        load;
  logic        phase_q, phase_d;
  logic        dropping_q, dropping_d;
  logic [15:0] count_q, count_d;
  logic [15:0] max_q, max_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign max_d     = cfg_we_i ? cfg_wdata_i : max_q;

  always_comb begin
    pop_o       = 1'b0;
    load        = 1'b0;
    phase_d     = phase_q;
    dropping_d  = dropping_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = head_i.byte1;
    out_last_d  = head_i.last;
    out_abort_d = 1'b0;
    if (head_valid_i) begin
      if (dropping_q) begin
        // discard until the frame's last item
        pop_o = 1'b1;
        if (head_i.last) begin
          dropping_d = 1'b0;
          count_d    = '0;
        end
      end else if (slot_free) begin
        load        = 1'b1;
        out_valid_d = 1'b1;
        if (count_q >= max_q) begin
          // limit reached: abort in place of this byte
          out_byte_d  = 8'h00;
          out_last_d  = 1'b1;
          out_abort_d = 1'b1;
          pop_o       = 1'b1;
          phase_d     = 1'b0;
          if (head_i.last) begin
            count_d = '0;
          end else begin
            dropping_d = 1'b1;
          end
        end else begin
          out_byte_d = phase_q ? head_i.byte2 : head_i.byte1;
          count_d    = count_q + 16'd1;
          if (head_i.two && !phase_q) begin
            phase_d = 1'b1;
          end else begin
            pop_o   = 1'b1;
            phase_d = 1'b0;
            if (head_i.last) begin
              count_d = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      dropping_q  <= 1'b0;
      count_q     <= '0;
      max_q       <= bsfe_pkg::MaxOutReset;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      dropping_q  <= dropping_d;
      count_q     <= count_d;
      max_q       <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q  <= out_byte_d;
      out_last_q  <= out_last_d;
      out_abort_q <= out_abort_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_abort_o = out_abort_q;

  // second half of an escape only while its entry waits at the head
  `BSFE_ASSERT(phase_needs_head, clk_i, rst_ni, phase_q |-> (head_valid_i && head_i.two))
  // a dropped frame never sits halfway through an escape
  `BSFE_ASSERT(drop_not_mid_escape, clk_i, rst_ni, !(dropping_q && phase_q))
  // entering the second half means the escape byte was just loaded
  `BSFE_ASSERT(escape_first, clk_i, rst_ni,
               $rose(phase_q) |-> (out_valid_q && out_byte_q == bsfe_pkg::EscByte))
  // an abort always starts dropping or closes the frame
  `BSFE_ASSERT(abort_ends_frame, clk_i, rst_ni,
               (load && out_abort_d) |=> (dropping_q || count_q == 16'd0))

endmodule

`default_nettype wire
